// ----- rtl/assert_macros.svh -----
// assertion helpers shared by the checker
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// plain property, sampled on the rising clock, muted during reset
`define FPC_ASSERT(name, clk, rst, prop) \
   name: assert property (@(posedge clk) disable iff (rst) (prop)) \
      else $error("fpc assertion failed");

// condition now implies a condition in the next cycle
`define FPC_ASSERT_NEXT(name, clk, rst, cond, nxt) \
   name: assert property (@(posedge clk) disable iff (rst) (cond) |=> (nxt)) \
      else $error("fpc assertion failed");

`endif

// ----- rtl/fpc_pkg.sv -----
`default_nettype none
package fpc_pkg;
   localparam int TABLE_DEPTH = 256;
   localparam int IDX_W = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
   localparam int CNT_W = $clog2(TABLE_DEPTH + 1);
   localparam int CMP_W = 16;
   localparam int QUEUE_DEPTH = 4;
   localparam int QPTR_W = $clog2(QUEUE_DEPTH);
   localparam int ENTRY_W = 96;

   localparam logic [1:0] JOB_OTHER = 2'd0;
   localparam logic [1:0] JOB_PAIR  = 2'd1;
   localparam logic [1:0] JOB_READ  = 2'd2;

   typedef struct packed {
      logic [1:0]  kind;
      logic [31:0] src;
      logic [31:0] dst;
      logic [7:0]  idx;
   } job_type;

   typedef struct packed {
      logic    valid;
      job_type job;
   } push_type;

   function automatic logic [31:0] sat_inc(input logic [31:0] v);
      sat_inc = (v == 32'hFFFF_FFFF) ? v : v + 32'd1;
   endfunction
endpackage
`default_nettype wire

// ----- rtl/fpc_ram.sv -----
`default_nettype none
module fpc_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 16
) (
   input  wire logic                                      clock,
   input  wire logic                                      wr_en,
   input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] wr_addr,
   input  wire logic [WIDTH-1:0]                          wr_data,
   input  wire logic                                      rd_en,
   input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] rd_addr,
   output logic      [WIDTH-1:0]                          rd_data
);
   logic [WIDTH-1:0] mem [DEPTH];

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data <= mem[rd_addr];
      end
   end
endmodule
`default_nettype wire

// ----- rtl/fpc_front.sv -----
`default_nettype none
module fpc_front (
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire logic              accept,
   input  wire logic              action,
   input  wire logic [7:0]        data_byte,
   input  wire logic [7:0]        entry_index,
   output fpc_pkg::push_type      push
);
   import fpc_pkg::*;

   localparam logic [2:0] PH_LEN_LO = 3'd0;
   localparam logic [2:0] PH_LEN_HI = 3'd1;
   localparam logic [2:0] PH_ETH    = 3'd2;
   localparam logic [2:0] PH_IP     = 3'd3;
   localparam logic [2:0] PH_SKIP   = 3'd4;
   localparam logic [4:0] ETH_LAST  = 5'd13;
   localparam logic [4:0] IP_LAST   = 5'd19;
   localparam logic [15:0] ETH_LEN  = 16'd14;
   localparam logic [15:0] IP_LEN   = 16'd34;
   localparam logic [15:0] ETYPE_IPV4 = 16'h0800;

   logic [2:0]  phase_ff, phase_in;
   logic [4:0]  pos_ff, pos_in;
   logic [15:0] skip_ff, skip_in;
   logic [15:0] etype_ff, etype_in;
   logic [31:0] src_ff, src_in;
   logic [31:0] dst_ff, dst_in;
   logic [15:0] hdr_len;
   logic        finish;

   always_comb begin
      phase_in = phase_ff;
      pos_in   = pos_ff;
      skip_in  = skip_ff;
      etype_in = etype_ff;
      src_in   = src_ff;
      dst_in   = dst_ff;
      finish   = 1'b0;
      hdr_len  = ETH_LEN;
      push     = '0;
      if (accept && action) begin
         push.valid    = 1'b1;
         push.job.kind = JOB_READ;
         push.job.idx  = entry_index;
      end else if (accept) begin
         unique case (phase_ff)
            PH_LEN_HI: begin
               skip_in  = {data_byte, skip_ff[7:0]};
               pos_in   = '0;
               phase_in = PH_ETH;
            end
            PH_ETH: begin
               if (pos_ff == ETH_LAST - 5'd1) begin
                  etype_in = {data_byte, etype_ff[7:0]};
               end else if (pos_ff == ETH_LAST) begin
                  etype_in = {etype_ff[15:8], data_byte};
               end
               if (pos_ff != ETH_LAST) begin
                  pos_in = pos_ff + 5'd1;
               end else if ({etype_ff[15:8], data_byte} == ETYPE_IPV4) begin
                  pos_in   = '0;
                  phase_in = PH_IP;
               end else begin
                  finish        = 1'b1;
                  push.valid    = 1'b1;
                  push.job.kind = JOB_OTHER;
               end
            end
            PH_IP: begin
               if (pos_ff >= 5'd12 && pos_ff < 5'd16) begin
                  src_in = {src_ff[23:0], data_byte};
               end else if (pos_ff >= 5'd16) begin
                  dst_in = {dst_ff[23:0], data_byte};
               end
               if (pos_ff != IP_LAST) begin
                  pos_in = pos_ff + 5'd1;
               end else begin
                  finish        = 1'b1;
                  hdr_len       = IP_LEN;
                  push.valid    = 1'b1;
                  push.job.kind = JOB_PAIR;
                  push.job.src  = src_ff;
                  push.job.dst  = {dst_ff[23:0], data_byte};
               end
            end
            PH_SKIP: begin
               skip_in = skip_ff - 16'd1;
               if (skip_ff == 16'd1) begin
                  phase_in = PH_LEN_LO;
               end
            end
            default: begin
               skip_in  = {8'd0, data_byte};
               pos_in   = '0;
               phase_in = PH_LEN_HI;
            end
         endcase
         if (finish) begin
            skip_in  = (skip_ff > hdr_len) ? skip_ff - hdr_len : 16'd0;
            pos_in   = '0;
            phase_in = (skip_ff > hdr_len) ? PH_SKIP : PH_LEN_LO;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff <= PH_LEN_LO;
         pos_ff   <= '0;
         skip_ff  <= '0;
         etype_ff <= '0;
         src_ff   <= '0;
         dst_ff   <= '0;
      end else begin
         phase_ff <= phase_in;
         pos_ff   <= pos_in;
         skip_ff  <= skip_in;
         etype_ff <= etype_in;
         src_ff   <= src_in;
         dst_ff   <= dst_in;
      end
   end
endmodule
`default_nettype wire

// ----- rtl/fpc_queue.sv -----
`default_nettype none
module fpc_queue (
   input  wire logic         clock,
   input  wire logic         reset,
   input  fpc_pkg::push_type push,
   output logic              full,
   input  wire logic         pop,
   output logic              pop_valid,
   output fpc_pkg::job_type  pop_job
);
   import fpc_pkg::*;

   job_type            slot_ff [QUEUE_DEPTH];
   logic [QPTR_W-1:0]  wp_ff, wp_in, rp_ff, rp_in;
   logic [QPTR_W:0]    cnt_ff, cnt_in;

   assign full      = (cnt_ff == (QPTR_W+1)'(QUEUE_DEPTH));
   assign pop_valid = (cnt_ff != '0);
   assign pop_job   = slot_ff[rp_ff];

   always_comb begin
      wp_in  = push.valid ? wp_ff + 1'b1 : wp_ff;
      rp_in  = pop ? rp_ff + 1'b1 : rp_ff;
      cnt_in = cnt_ff + (QPTR_W+1)'(push.valid) - (QPTR_W+1)'(pop);
   end

   always_ff @(posedge clock) begin
      if (push.valid) begin
         slot_ff[wp_ff] <= push.job;
      end
      if (reset) begin
         wp_ff  <= '0;
         rp_ff  <= '0;
         cnt_ff <= '0;
      end else begin
         wp_ff  <= wp_in;
         rp_ff  <= rp_in;
         cnt_ff <= cnt_in;
      end
   end
endmodule
`default_nettype wire

// ----- rtl/fpc_back.sv -----
`default_nettype none
module fpc_back (
   input  wire logic         clock,
   input  wire logic         reset,
   input  wire logic         job_valid,
   input  fpc_pkg::job_type  job,
   output logic              job_pop,
   input  wire logic         rsp_stall,
   output logic              rsp_valid,
   output logic              rsp_report_kind,
   output logic              rsp_is_ipv4,
   output logic [31:0]       rsp_source_address,
   output logic [31:0]       rsp_dest_address,
   output logic [31:0]       rsp_pair_count,
   output logic              rsp_entry_valid,
   output logic              rsp_table_full_drop,
   output logic [31:0]       rsp_records_total,
   output logic [31:0]       rsp_records_ipv4,
   output logic [31:0]       rsp_records_other
);
   import fpc_pkg::*;

   localparam logic [1:0] B_IDLE   = 2'd0;
   localparam logic [1:0] B_CMP    = 2'd1;
   localparam logic [1:0] B_APPEND = 2'd2;
   localparam logic [1:0] B_RDATA  = 2'd3;

   logic [1:0]       state_ff, state_in;
   logic [CNT_W-1:0] used_ff, used_in, scan_ff, scan_in;
   logic [31:0]      tot_ff, tot_in, ipv_ff, ipv_in, oth_ff, oth_in;
   logic [31:0]      src_ff, src_in, dst_ff, dst_in;
   logic             rsp_valid_ff, rsp_valid_in;
   logic             kind_ff, v4_ff, ev_ff, drop_ff;
   logic [31:0]      osrc_ff, odst_ff, ocnt_ff;
   logic             emit, e_kind, e_v4, e_ev, e_drop;
   logic [31:0]      e_src, e_dst, e_cnt;
   logic             rd_en, wr_en;
   logic [IDX_W-1:0] rd_addr, wr_addr;
   logic [ENTRY_W-1:0] wr_data, rd_data;
   logic [CMP_W-1:0] idx_ext, used_ext, next_ext;
   logic             slot_free;

   fpc_ram #(.WIDTH(ENTRY_W), .DEPTH(TABLE_DEPTH)) u_table (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (wr_addr),
      .wr_data (wr_data),
      .rd_en   (rd_en),
      .rd_addr (rd_addr),
      .rd_data (rd_data)
   );

   assign slot_free = !rsp_valid_ff || !rsp_stall;
   assign idx_ext   = CMP_W'(job.idx);
   assign used_ext  = CMP_W'(used_ff);
   assign next_ext  = CMP_W'(scan_ff) + CMP_W'(1);

   always_comb begin
      state_in = state_ff;
      used_in  = used_ff;
      scan_in  = scan_ff;
      tot_in   = tot_ff;
      ipv_in   = ipv_ff;
      oth_in   = oth_ff;
      src_in   = src_ff;
      dst_in   = dst_ff;
      job_pop  = 1'b0;
      emit     = 1'b0;
      e_kind   = 1'b0;
      e_v4     = 1'b0;
      e_ev     = 1'b0;
      e_drop   = 1'b0;
      e_src    = '0;
      e_dst    = '0;
      e_cnt    = '0;
      rd_en    = 1'b0;
      rd_addr  = '0;
      wr_en    = 1'b0;
      wr_addr  = '0;
      wr_data  = '0;
      unique case (state_ff)
         B_IDLE: begin
            if (job_valid && slot_free) begin
               job_pop = 1'b1;
               unique case (job.kind)
                  JOB_OTHER: begin
                     tot_in = sat_inc(tot_ff);
                     oth_in = sat_inc(oth_ff);
                     emit   = 1'b1;
                  end
                  JOB_PAIR: begin
                     tot_in = sat_inc(tot_ff);
                     ipv_in = sat_inc(ipv_ff);
                     src_in = job.src;
                     dst_in = job.dst;
                     scan_in = '0;
                     if (used_ff == '0) begin
                        state_in = B_APPEND;
                     end else begin
                        rd_en    = 1'b1;
                        state_in = B_CMP;
                     end
                  end
                  default: begin
                     if (idx_ext < used_ext) begin
                        rd_en    = 1'b1;
                        rd_addr  = idx_ext[IDX_W-1:0];
                        state_in = B_RDATA;
                     end else begin
                        emit   = 1'b1;
                        e_kind = 1'b1;
                     end
                  end
               endcase
            end
         end
         B_CMP: begin
            if (rd_data[95:64] == src_ff && rd_data[63:32] == dst_ff) begin
               wr_en    = 1'b1;
               wr_addr  = scan_ff[IDX_W-1:0];
               wr_data  = {src_ff, dst_ff, sat_inc(rd_data[31:0])};
               emit     = 1'b1;
               e_v4     = 1'b1;
               e_ev     = 1'b1;
               e_src    = src_ff;
               e_dst    = dst_ff;
               e_cnt    = sat_inc(rd_data[31:0]);
               state_in = B_IDLE;
            end else if (next_ext < used_ext) begin
               scan_in = next_ext[CNT_W-1:0];
               rd_en   = 1'b1;
               rd_addr = next_ext[IDX_W-1:0];
            end else begin
               state_in = B_APPEND;
            end
         end
         B_APPEND: begin
            emit     = 1'b1;
            e_v4     = 1'b1;
            e_src    = src_ff;
            e_dst    = dst_ff;
            state_in = B_IDLE;
            if (used_ext < CMP_W'(TABLE_DEPTH)) begin
               wr_en   = 1'b1;
               wr_addr = used_ff[IDX_W-1:0];
               wr_data = {src_ff, dst_ff, 32'd1};
               used_in = used_ff + 1'b1;
               e_ev    = 1'b1;
               e_cnt   = 32'd1;
            end else begin
               e_drop = 1'b1;
            end
         end
         default: begin
            emit     = 1'b1;
            e_kind   = 1'b1;
            e_ev     = 1'b1;
            e_src    = rd_data[95:64];
            e_dst    = rd_data[63:32];
            e_cnt    = rd_data[31:0];
            state_in = B_IDLE;
         end
      endcase
      rsp_valid_in = (rsp_valid_ff && rsp_stall) || emit;
   end

   always_ff @(posedge clock) begin
      if (emit) begin
         kind_ff <= e_kind;
         v4_ff   <= e_v4;
         ev_ff   <= e_ev;
         drop_ff <= e_drop;
         osrc_ff <= e_src;
         odst_ff <= e_dst;
         ocnt_ff <= e_cnt;
      end
      src_ff  <= src_in;
      dst_ff  <= dst_in;
      scan_ff <= scan_in;
      if (reset) begin
         state_ff     <= B_IDLE;
         used_ff      <= '0;
         tot_ff       <= '0;
         ipv_ff       <= '0;
         oth_ff       <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         used_ff      <= used_in;
         tot_ff       <= tot_in;
         ipv_ff       <= ipv_in;
         oth_ff       <= oth_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   assign rsp_valid           = rsp_valid_ff;
   assign rsp_report_kind     = kind_ff;
   assign rsp_is_ipv4         = v4_ff;
   assign rsp_source_address  = osrc_ff;
   assign rsp_dest_address    = odst_ff;
   assign rsp_pair_count      = ocnt_ff;
   assign rsp_entry_valid     = ev_ff;
   assign rsp_table_full_drop = drop_ff;
   assign rsp_records_total   = tot_ff;
   assign rsp_records_ipv4    = ipv_ff;
   assign rsp_records_other   = oth_ff;
endmodule
`default_nettype wire

// ----- rtl/ipv4_flow_pair_counter.sv -----
// ipv4 flow pair counter
// req channel: one beat per stream byte (req_action 0) or per table read
// (req_action 1, req_entry_index picks the entry); req_stall holds the sender
// rsp channel: one beat per finished record header and one per table read
// a front parser takes a beat per cycle while its job queue (4 deep) has room
// a back sequencer runs queued jobs in order against a table ram with one read and one write port
// a non-ipv4 record or a table read past the fill count is answered from idle; a read within it reads the ram first
// an ipv4 pair scans the table one entry a cycle until it finds the pair or reaches the fill count
// the table scan sets throughput; ipv4 records are at least 36 beats long, so the
// stream keeps flowing unless many short records or reads come back to back
// when the receiver stalls, the result register holds and the back waits;
// the front keeps taking beats until the queue fills, then raises req_stall
// reset (synchronous, active high) clears the parser, queue, counters and the
// table fill count; table contents need no clearing
`default_nettype none
module ipv4_flow_pair_counter (
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        req_valid,
   output logic             req_stall,
   input  wire logic        req_action,
   input  wire logic [7:0]  req_data_byte,
   input  wire logic [7:0]  req_entry_index,
   output logic             rsp_valid,
   input  wire logic        rsp_stall,
   output logic             rsp_report_kind,
   output logic             rsp_is_ipv4,
   output logic [31:0]      rsp_source_address,
   output logic [31:0]      rsp_dest_address,
   output logic [31:0]      rsp_pair_count,
   output logic             rsp_entry_valid,
   output logic             rsp_table_full_drop,
   output logic [31:0]      rsp_records_total,
   output logic [31:0]      rsp_records_ipv4,
   output logic [31:0]      rsp_records_other
);
   import fpc_pkg::*;

   // front to queue
   push_type push;
   logic     q_full;
   // queue to back
   logic     q_valid, q_pop;
   job_type  q_job;
   logic     req_accept;

   // a beat is taken whenever the queue can hold the job it might make
   assign req_stall  = q_full;
   assign req_accept = req_valid && !q_full;

   fpc_front u_front (
      .clock       (clock),
      .reset       (reset),
      .accept      (req_accept),
      .action      (req_action),
      .data_byte   (req_data_byte),
      .entry_index (req_entry_index),
      .push        (push)
   );

   fpc_queue u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (push),
      .full      (q_full),
      .pop       (q_pop),
      .pop_valid (q_valid),
      .pop_job   (q_job)
   );

   // back owns the counters, the table and the result register
   fpc_back u_back (
      .clock               (clock),
      .reset               (reset),
      .job_valid           (q_valid),
      .job                 (q_job),
      .job_pop             (q_pop),
      .rsp_stall           (rsp_stall),
      .rsp_valid           (rsp_valid),
      .rsp_report_kind     (rsp_report_kind),
      .rsp_is_ipv4         (rsp_is_ipv4),
      .rsp_source_address  (rsp_source_address),
      .rsp_dest_address    (rsp_dest_address),
      .rsp_pair_count      (rsp_pair_count),
      .rsp_entry_valid     (rsp_entry_valid),
      .rsp_table_full_drop (rsp_table_full_drop),
      .rsp_records_total   (rsp_records_total),
      .rsp_records_ipv4    (rsp_records_ipv4),
      .rsp_records_other   (rsp_records_other)
   );
endmodule
`default_nettype wire

// ----- rtl/fpc_checker.sv -----
`default_nettype none
`include "assert_macros.svh"
module fpc_checker (
   input wire logic        clock,
   input wire logic        reset,
   input wire logic        req_valid,
   input wire logic        req_stall,
   input wire logic        req_action,
   input wire logic [7:0]  req_data_byte,
   input wire logic [7:0]  req_entry_index,
   input wire logic        rsp_valid,
   input wire logic        rsp_stall,
   input wire logic        rsp_report_kind,
   input wire logic        rsp_is_ipv4,
   input wire logic [31:0] rsp_source_address,
   input wire logic [31:0] rsp_dest_address,
   input wire logic [31:0] rsp_pair_count,
   input wire logic        rsp_entry_valid,
   input wire logic        rsp_table_full_drop,
   input wire logic [31:0] rsp_records_total,
   input wire logic [31:0] rsp_records_ipv4,
   input wire logic [31:0] rsp_records_other
);
   // a stalled result keeps its source address and pair count
   `FPC_ASSERT_NEXT(a_hold, clock, reset, rsp_valid && rsp_stall, rsp_valid && $stable(rsp_source_address) && $stable(rsp_pair_count))
   // a read never reports a drop or an ipv4 record
   `FPC_ASSERT(a_read_flags, clock, reset, !(rsp_valid && rsp_report_kind) || (!rsp_is_ipv4 && !rsp_table_full_drop))
   // a dropped pair is never a held entry and carries a zero pair count
   `FPC_ASSERT(a_drop_excl, clock, reset, !(rsp_valid && rsp_table_full_drop) || (!rsp_entry_valid && rsp_pair_count == 32'd0))
   // a non-ipv4 record carries a zero source address and no valid entry
   `FPC_ASSERT(a_other_zero, clock, reset, !(rsp_valid && !rsp_report_kind && !rsp_is_ipv4) || (rsp_source_address == 32'd0 && !rsp_entry_valid))
endmodule
bind ipv4_flow_pair_counter fpc_checker u_fpc_checker (.*);
`default_nettype wire

// ----- verif/ipv4_flow_pair_checker.sv -----
`default_nettype none
module ipv4_flow_pair_checker (
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        req_valid,
   input  wire logic        req_stall,
   input  wire logic        req_action,
   input  wire logic [7:0]  req_data_byte,
   input  wire logic [7:0]  req_entry_index,
   input  wire logic        rsp_valid,
   input  wire logic        rsp_stall,
   input  wire logic        rsp_report_kind,
   input  wire logic        rsp_is_ipv4,
   input  wire logic [31:0] rsp_source_address,
   input  wire logic [31:0] rsp_dest_address,
   input  wire logic [31:0] rsp_pair_count,
   input  wire logic        rsp_entry_valid,
   input  wire logic        rsp_table_full_drop,
   input  wire logic [31:0] rsp_records_total,
   input  wire logic [31:0] rsp_records_ipv4,
   input  wire logic [31:0] rsp_records_other,
   output int               fail_count,
   output int               pending
);
   timeunit 1ns;
   timeprecision 1ps;
   import fpc_pkg::*;

   typedef enum logic [2:0] {
      WAIT_LEN_LO, WAIT_LEN_HI, IN_ETH, IN_IP, IN_SKIP
   } parse_state_type;

   typedef struct packed {
      logic        kind;
      logic        v4;
      logic [31:0] src;
      logic [31:0] dst;
      logic [31:0] cnt;
      logic        hit_valid;
      logic        drop;
      logic [31:0] total;
      logic [31:0] ipv4;
      logic [31:0] other;
   } flow_report_type;

   parse_state_type state;
   logic [4:0]   pos;
   logic [15:0]  remain;
   logic [15:0]  ethertype;
   logic [31:0]  src_lat, dst_lat;
   logic [31:0]  pair_src [TABLE_DEPTH];
   logic [31:0]  pair_dst [TABLE_DEPTH];
   logic [31:0]  pair_cnt [TABLE_DEPTH];
   int           used;
   logic [31:0]  n_total, n_ipv4, n_other;
   flow_report_type reports_due [$];

   function automatic logic [31:0] bump(input logic [31:0] v);
      return (v == 32'hFFFF_FFFF) ? v : v + 32'd1;
   endfunction

   function automatic flow_report_type base_report(input logic kind, input logic v4);
      flow_report_type r;
      r = '0;
      r.kind = kind;
      r.v4 = v4;
      r.total = n_total;
      r.ipv4 = n_ipv4;
      r.other = n_other;
      return r;
   endfunction

   // header done: skip what the length leaves, or start a new record
   task automatic close_headers(input int hdr);
      remain = (int'(remain) > hdr) ? remain - 16'(hdr) : 16'd0;
      pos = '0;
      state = (remain != 0) ? IN_SKIP : WAIT_LEN_LO;
   endtask

   task automatic predict_beat(input logic act, input logic [7:0] b, input logic [7:0] idx);
      flow_report_type r;
      bit found;
      if (act) begin
         r = base_report(1'b1, 1'b0);
         if (int'(idx) < used) begin
            r.src = pair_src[idx];
            r.dst = pair_dst[idx];
            r.cnt = pair_cnt[idx];
            r.hit_valid = 1'b1;
         end
         reports_due.push_back(r);
         return;
      end
      case (state)
         WAIT_LEN_HI: begin
            remain[15:8] = b;
            pos = '0;
            state = IN_ETH;
         end
         IN_ETH: begin
            if (pos == 12) ethertype[15:8] = b;
            else if (pos == 13) ethertype[7:0] = b;
            if (pos < 13) pos++;
            else if (ethertype == 16'h0800) begin
               pos = '0;
               state = IN_IP;
            end else begin
               n_total = bump(n_total);
               n_other = bump(n_other);
               close_headers(14);
               reports_due.push_back(base_report(1'b0, 1'b0));
            end
         end
         IN_IP: begin
            if (pos >= 12 && pos < 16) src_lat = {src_lat[23:0], b};
            else if (pos >= 16) dst_lat = {dst_lat[23:0], b};
            if (pos < 19) pos++;
            else begin
               n_total = bump(n_total);
               n_ipv4 = bump(n_ipv4);
               close_headers(34);
               r = base_report(1'b0, 1'b1);
               r.src = src_lat;
               r.dst = dst_lat;
               found = 0;
               for (int i = 0; i < used && !found; i++) begin
                  if (pair_src[i] == src_lat && pair_dst[i] == dst_lat) begin
                     pair_cnt[i] = bump(pair_cnt[i]);
                     r.cnt = pair_cnt[i];
                     r.hit_valid = 1'b1;
                     found = 1;
                  end
               end
               if (!found) begin
                  if (used < TABLE_DEPTH) begin
                     pair_src[used] = src_lat;
                     pair_dst[used] = dst_lat;
                     pair_cnt[used] = 32'd1;
                     used++;
                     r.cnt = 32'd1;
                     r.hit_valid = 1'b1;
                  end else begin
                     r.drop = 1'b1;
                  end
               end
               reports_due.push_back(r);
            end
         end
         IN_SKIP: begin
            if (remain != 0) remain--;
            if (remain == 0) state = WAIT_LEN_LO;
         end
         default: begin
            remain = {8'd0, b};
            pos = '0;
            state = WAIT_LEN_HI;
         end
      endcase
   endtask

   task automatic report_mismatch(input string what, input logic [31:0] got,
                                  input logic [31:0] want);
      $display("%0t mismatch %s: got %h want %h", $realtime, what, got, want);
      fail_count++;
   endtask

   initial begin
      fail_count = 0;
      pending = 0;
   end

   always @(posedge clock) begin
      flow_report_type e;
      if (reset) begin
         state = WAIT_LEN_LO;
         pos = '0;
         remain = '0;
         ethertype = '0;
         src_lat = '0;
         dst_lat = '0;
         used = 0;
         n_total = '0;
         n_ipv4 = '0;
         n_other = '0;
         reports_due.delete();
      end else begin
         if (req_valid && !req_stall)
            predict_beat(req_action, req_data_byte, req_entry_index);
         if (rsp_valid && !rsp_stall) begin
            if (reports_due.size() == 0) begin
               report_mismatch("unexpected beat", rsp_records_total, 32'd0);
            end else begin
               e = reports_due.pop_front();
               if (rsp_report_kind != e.kind)
                  report_mismatch("report_kind", rsp_report_kind, e.kind);
               if (rsp_is_ipv4 != e.v4) report_mismatch("is_ipv4", rsp_is_ipv4, e.v4);
               if (rsp_source_address != e.src)
                  report_mismatch("source_address", rsp_source_address, e.src);
               if (rsp_dest_address != e.dst)
                  report_mismatch("dest_address", rsp_dest_address, e.dst);
               if (rsp_pair_count != e.cnt)
                  report_mismatch("pair_count", rsp_pair_count, e.cnt);
               if (rsp_entry_valid != e.hit_valid)
                  report_mismatch("entry_valid", rsp_entry_valid, e.hit_valid);
               if (rsp_table_full_drop != e.drop)
                  report_mismatch("table_full_drop", rsp_table_full_drop, e.drop);
               if (rsp_records_total != e.total)
                  report_mismatch("records_total", rsp_records_total, e.total);
               if (rsp_records_ipv4 != e.ipv4)
                  report_mismatch("records_ipv4", rsp_records_ipv4, e.ipv4);
               if (rsp_records_other != e.other)
                  report_mismatch("records_other", rsp_records_other, e.other);
            end
         end
      end
      pending = reports_due.size();
   end
endmodule
`default_nettype wire

// ----- verif/tb_ipv4_flow_pair_counter.sv -----
`default_nettype none
module tb_ipv4_flow_pair_counter;
   timeunit 1ns;
   timeprecision 1ps;

   localparam int CYCLE_LIMIT = 4_000_000;

   logic        clock;
   logic        reset;
   logic        req_valid;
   logic        req_stall;
   logic        req_action;
   logic [7:0]  req_data_byte;
   logic [7:0]  req_entry_index;
   logic        rsp_valid;
   logic        rsp_stall;
   logic        rsp_report_kind;
   logic        rsp_is_ipv4;
   logic [31:0] rsp_source_address;
   logic [31:0] rsp_dest_address;
   logic [31:0] rsp_pair_count;
   logic        rsp_entry_valid;
   logic        rsp_table_full_drop;
   logic [31:0] rsp_records_total;
   logic [31:0] rsp_records_ipv4;
   logic [31:0] rsp_records_other;
   int          fail_count;
   int          pending;

   // stimulus control
   int          beats_sent;
   bit          quiet;       // no idling on either side
   bit          hold_req;    // ask the receiver for one long hold-off
   bit          hold_done;
   logic [31:0] src_pool [8];
   logic [31:0] dst_pool [8];

   ipv4_flow_pair_counter uut (.*);

   ipv4_flow_pair_checker chk (.*);

   // 20 ns clock
   always begin
      clock = 1'b1;
      #10;
      clock = 1'b0;
      #10;
   end

   // watchdog on total run length
   initial begin
      int cycles;
      cycles = 0;
      while (cycles < CYCLE_LIMIT) begin
         @(posedge clock);
         cycles++;
      end
      $display("tb_ipv4_flow_pair_counter NOT OK");
      $finish;
   end

   // receiver: random stall bursts, one long hold-off on request
   initial begin
      int n;
      rsp_stall = 1'b0;
      forever begin
         if (hold_req) begin
            // long hold-off so the job queue fills and req_stall rises
            for (n = 0; n < 600; n++) begin
               rsp_stall <= 1'b1;
               @(negedge clock);
            end
            hold_req = 0;
         end else if (quiet || $urandom_range(0, 3) != 0) begin
            n = $urandom_range(1, 30);
            repeat (n) begin
               rsp_stall <= 1'b0;
               @(negedge clock);
            end
         end else begin
            n = $urandom_range(1, 19);
            repeat (n) begin
               rsp_stall <= 1'b1;
               @(negedge clock);
            end
         end
      end
   end

   // one beat; an idle burst may come first; called at a falling edge
   task automatic send_beat(input logic act, input logic [7:0] b, input logic [7:0] idx);
      if (!quiet && $urandom_range(0, 15) == 0) begin
         req_valid <= 1'b0;
         repeat ($urandom_range(1, 19)) @(negedge clock);
      end
      req_valid <= 1'b1;
      req_action <= act;
      req_data_byte <= b;
      req_entry_index <= idx;
      do @(posedge clock); while (req_stall);
      beats_sent++;
      @(negedge clock);
   endtask

   // stream byte, sometimes preceded by a table read that must not upset the parse
   task automatic send_byte(input logic [7:0] b, input int read_odds);
      if (read_odds > 0 && $urandom_range(1, 100) <= read_odds)
         send_beat(1'b1, 8'($urandom), 8'($urandom));
      send_beat(1'b0, b, 8'($urandom));
   endtask

   task automatic send_record(input logic [15:0] len, input logic [15:0] etype,
                              input logic [31:0] src, input logic [31:0] dst,
                              input int read_odds);
      int hdr;
      send_byte(len[7:0], read_odds);
      send_byte(len[15:8], read_odds);
      for (int i = 0; i < 14; i++)
         send_byte((i == 12) ? etype[15:8] : (i == 13) ? etype[7:0] : 8'($urandom),
                   read_odds);
      hdr = 14;
      if (etype == 16'h0800) begin
         hdr = 34;
         for (int i = 0; i < 20; i++) begin
            if (i >= 12 && i < 16) send_byte(src[8*(15-i) +: 8], read_odds);
            else if (i >= 16) send_byte(dst[8*(19-i) +: 8], read_odds);
            else send_byte(8'($urandom), read_odds);
         end
      end
      // payload that the block skips
      for (int i = hdr; i < int'(len); i++) send_byte(8'($urandom), read_odds);
   endtask

   initial begin
      int pick;
      logic [15:0] len;
      logic [15:0] etype;
      logic [31:0] s, d;
      reset = 1'b1;
      req_valid = 1'b0;
      req_action = 1'b0;
      req_data_byte = 8'd0;
      req_entry_index = 8'd0;
      beats_sent = 0;
      quiet = 0;
      hold_req = 0;
      hold_done = 0;
      for (int i = 0; i < 8; i++) begin
         src_pool[i] = $urandom;
         dst_pool[i] = $urandom;
      end
      repeat (10) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      // directed: reads of an empty table, both extremes of the index
      send_beat(1'b1, 8'hFF, 8'd0);
      send_beat(1'b1, 8'h00, 8'd255);
      // non-ipv4 with a length too short to skip anything
      send_record(16'd0, 16'h0008, '0, '0, 0);
      // ipv4 with exact header length, then a repeat of the pair (hit)
      send_record(16'd34, 16'h0800, 32'h0000_0000, 32'hFFFF_FFFF, 0);
      send_record(16'd34, 16'h0800, 32'h0000_0000, 32'hFFFF_FFFF, 0);
      // ipv4 with a short length, then one with a payload to skip
      send_record(16'd5, 16'h0800, 32'hFFFF_FFFF, 32'h0000_0000, 0);
      send_record(16'd40, 16'h0800, 32'h0102_0304, 32'h0506_0708, 0);
      // near-miss ethertype with a payload, and a length with its high byte set
      send_record(16'd20, 16'h0801, '0, '0, 0);
      send_record(16'h0130, 16'hFFFF, '0, '0, 0);
      send_beat(1'b1, 8'h00, 8'd0);
      send_beat(1'b1, 8'h00, 8'd2);
      send_beat(1'b1, 8'h00, 8'd3);

      // random part: mostly well-formed records with random content
      while (beats_sent < 1380) begin
         if (!hold_done && beats_sent > 800) begin
            hold_req = 1;
            hold_done = 1;
         end
         pick = $urandom_range(0, 99);
         if (pick < 80) begin
            len = ($urandom_range(0, 9) == 0) ? 16'($urandom_range(0, 120))
                                              : 16'($urandom_range(30, 48));
            etype = ($urandom_range(0, 5) == 0) ? 16'($urandom) : 16'h0800;
            s = ($urandom_range(0, 9) < 7) ? src_pool[$urandom_range(0, 7)] : $urandom;
            d = ($urandom_range(0, 9) < 7) ? dst_pool[$urandom_range(0, 7)] : $urandom;
            send_record(len, etype, s, d, $urandom_range(0, 1) * 5);
         end else if (pick < 90) begin
            // burst of reads, data_byte content is ignored
            repeat ($urandom_range(1, 8))
               send_beat(1'b1, 8'($urandom),
                         ($urandom_range(0, 1) != 0) ? 8'($urandom_range(0, 20))
                                                     : 8'($urandom));
         end else begin
            // broken record: length under 34, shorter than the headers when it is ipv4
            send_record(16'($urandom_range(0, 33)), 16'($urandom_range(0, 1) ? 16'h0800
                        : 16'($urandom)), $urandom, $urandom, 10);
         end
      end

      // last part, no idling: new pairs back to back, then a pool pair, one more pair and reads
      quiet = 1;
      for (int i = 0; i < 8; i++)
         send_record(16'd34, 16'h0800, 32'hC0A8_0000 + i, $urandom, 0);
      send_record(16'd34, 16'h0800, src_pool[0], dst_pool[0], 0);
      send_record(16'd34, 16'h0800, 32'hC0A8_0000, 32'h0, 0);
      for (int i = 0; i < 4; i++) send_beat(1'b1, 8'($urandom), 8'($urandom));
      send_beat(1'b1, 8'h00, 8'd255);
      req_valid <= 1'b0;

      while (pending != 0) @(posedge clock);
      repeat (400) @(posedge clock);
      if (fail_count == 0 && pending == 0) begin
         $display("tb_ipv4_flow_pair_counter OK");
      end else begin
         $display("tb_ipv4_flow_pair_counter NOT OK");
      end
      $finish;
   end
endmodule
`default_nettype wire
